@@ design/utf8d_pkg.sv @@
`timescale 1ns / 1ps
package utf8d_pkg;

   localparam int unsigned CP_W = 21;

   localparam logic [7:0] LEAD2_LO   = 8'hc2;
   localparam logic [7:0] LEAD2_HI   = 8'hdf;
   localparam logic [7:0] LEAD4_HI   = 8'hf4;
   localparam logic [7:0] CONT_MASK  = 8'hc0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] ASCII_LIM  = 8'h80;
   localparam logic [3:0] LEAD3_NIB  = 4'he;
   localparam logic [3:0] LEAD4_NIB  = 4'hf;

   localparam logic [CP_W-1:0] MIN_LEN2  = 21'h000080;
   localparam logic [CP_W-1:0] MIN_LEN3  = 21'h000800;
   localparam logic [CP_W-1:0] MIN_LEN4  = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;
   localparam logic [CP_W-1:0] SURR_LO   = 21'h00d800;
   localparam logic [CP_W-1:0] SURR_HI   = 21'h00dfff;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   // results of one input byte: a number of error items, then an optional code point
   typedef struct packed {
      logic [2:0]      err_count;
      logic            has_cp;
      logic [CP_W-1:0] cp;
   } run_type;

endpackage

@@ design/utf8d_if.sv @@
`timescale 1ns / 1ps
interface utf8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        is_error;
   logic        last_of_run;

   modport source (output valid, output code_point, output is_error, output last_of_run,
                   input ready);
   modport sink (input valid, input code_point, input is_error, input last_of_run,
                 output ready);
endinterface

@@ design/utf8d_decode.sv @@
`timescale 1ns / 1ps
module utf8d_decode
   import utf8d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic [7:0] data_byte,
   input  logic    end_of_text,
   output run_type run
);

   logic [1:0]      held_ff, held_in;
   logic [2:0]      len_ff, len_in;
   logic [CP_W-1:0] acc_ff, acc_in;

   logic            is_cont;
   logic [CP_W-1:0] acc_shift;
   logic [CP_W-1:0] min_val;
   logic            value_ok;
   logic [2:0]      errs;

   always_comb begin
      is_cont   = (data_byte & CONT_MASK) == CONT_CODE;
      acc_shift = {acc_ff[CP_W-7:0], data_byte[5:0]};
      unique case (len_ff)
         LEN_TWO:   min_val = MIN_LEN2;
         LEN_THREE: min_val = MIN_LEN3;
         default:   min_val = MIN_LEN4;
      endcase
      value_ok = (acc_shift >= min_val) && (acc_shift <= CP_MAX)
               && !((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

      held_in = held_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      errs    = 3'd0;
      run     = '0;

      if (held_ff != 2'd0 && is_cont) begin
         if ({1'b0, held_ff} + 3'd1 >= len_ff) begin
            if (value_ok) begin
               run.has_cp = 1'b1;
               run.cp     = acc_shift;
            end else begin
               errs = len_ff;
            end
            held_in = 2'd0;
            len_in  = LEN_NONE;
            acc_in  = '0;
         end else begin
            held_in = held_ff + 2'd1;
            acc_in  = acc_shift;
         end
      end else begin
         // no open sequence or a broken one, then the byte starts fresh
         errs    = {1'b0, held_ff};
         held_in = 2'd0;
         len_in  = LEN_NONE;
         acc_in  = '0;
         if (data_byte < ASCII_LIM) begin
            run.has_cp = 1'b1;
            run.cp     = {13'd0, data_byte};
         end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            held_in = 2'd1;
            len_in  = LEN_TWO;
            acc_in  = {16'd0, data_byte[4:0]};
         end else if (data_byte[7:4] == LEAD3_NIB) begin
            held_in = 2'd1;
            len_in  = LEN_THREE;
            acc_in  = {17'd0, data_byte[3:0]};
         end else if (data_byte[7:4] == LEAD4_NIB && data_byte <= LEAD4_HI) begin
            held_in = 2'd1;
            len_in  = LEN_FOUR;
            acc_in  = {18'd0, data_byte[2:0]};
         end else begin
            errs = errs + 3'd1;
         end
      end

      // end of text flushes an open sequence
      if (end_of_text && held_in != 2'd0) begin
         errs    = errs + {1'b0, held_in};
         held_in = 2'd0;
         len_in  = LEN_NONE;
         acc_in  = '0;
      end

      run.err_count = errs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         len_ff  <= LEN_NONE;
         acc_ff  <= '0;
      end else if (accept) begin
         held_ff <= held_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

@@ design/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// utf8_stream_decoder: validating UTF-8 byte stream decoder.
// req_chan carries one text byte per item with an end_of_text mark on the
// last byte of a text. rsp_chan carries code points or error markers; an
// error item has is_error set and code_point 0, and last_of_run marks the
// final item caused by one input byte. A byte may cause no item (it opens or
// extends a sequence) or up to four (errors for a broken sequence, then the
// byte itself, or a flush at end of text).
// An item's first result is registered and appears in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; a byte giving several results stalls the input while
// the single result register drains one item per cycle the receiver is ready.
// Reset clears any open sequence and drops pending results.
// When the receiver stalls, the pending result holds and a new byte is taken
// only in the cycle the last result of the previous byte is taken.
module utf8_stream_decoder
   import utf8d_pkg::*;
(
   input  logic clock,
   input  logic reset,
   utf8d_req_if.sink   req_chan,
   utf8d_rsp_if.source rsp_chan
);

   run_type         run;
   logic            accept;
   logic            rsp_last;
   logic [2:0]      err_left_ff, err_left_in;
   logic            cp_pend_ff, cp_pend_in;
   logic [CP_W-1:0] cp_ff, cp_in;

   utf8d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_chan.data_byte),
      .end_of_text (req_chan.end_of_text),
      .run         (run)
   );

   assign rsp_chan.valid       = (err_left_ff != 3'd0) || cp_pend_ff;
   assign rsp_last             = (err_left_ff == 3'd0) || (err_left_ff == 3'd1 && !cp_pend_ff);
   assign rsp_chan.is_error    = err_left_ff != 3'd0;
   assign rsp_chan.code_point  = (err_left_ff != 3'd0) ? '0 : cp_ff;
   assign rsp_chan.last_of_run = rsp_last;
   assign req_chan.ready       = !rsp_chan.valid || (rsp_chan.ready && rsp_last);
   assign accept               = req_chan.valid && req_chan.ready;

   always_comb begin
      err_left_in = err_left_ff;
      cp_pend_in  = cp_pend_ff;
      cp_in       = cp_ff;
      if (accept) begin
         err_left_in = run.err_count;
         cp_pend_in  = run.has_cp;
         cp_in       = run.cp;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         if (err_left_ff != 3'd0) begin
            err_left_in = err_left_ff - 3'd1;
         end else begin
            cp_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_left_ff <= 3'd0;
         cp_pend_ff  <= 1'b0;
      end else begin
         err_left_ff <= err_left_in;
         cp_pend_ff  <= cp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff <= cp_in;
   end

endmodule

@@ design/utf8d_checker.sv @@
`timescale 1ns / 1ps
module utf8d_checker
   import utf8d_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [CP_W-1:0] rsp_code_point,
   input logic            rsp_is_error,
   input logic            rsp_last_of_run
);

   // error items carry no code point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_error |-> rsp_code_point == '0)
      else $error("error item with nonzero code point");

   // decoded values are scalar values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_error |-> rsp_code_point <= CP_MAX
         && !(rsp_code_point >= SURR_LO && rsp_code_point <= SURR_HI))
      else $error("code point out of scalar range");

   // a code point is always the final item of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_error |-> rsp_last_of_run)
      else $error("code point not last of run");

   // reset drops pending results
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_code_point  (rsp_chan.code_point),
   .rsp_is_error    (rsp_chan.is_error),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

@@ verif/utf8_stream_decoder_checker.sv @@
`timescale 1ns / 1ps
module utf8_stream_decoder_checker
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if        req_chan,
   utf8d_rsp_if        rsp_chan,
   output int unsigned mismatch_count,
   output int unsigned results_owed,
   output int unsigned results_seen,
   output int unsigned error_results
);

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            err;
      logic            last;
   } decoded_type;

   decoded_type owed_q[$];

   // open sequence
   logic [1:0]      held;
   logic [2:0]      seq_len;
   logic [CP_W-1:0] acc;

   function automatic void owe_item(input decoded_type item);
      owed_q.insert(owed_q.size(), item);
   endfunction

   function automatic void close_sequence();
      held = '0;
      seq_len = LEN_NONE;
      acc = '0;
   endfunction

   function automatic void owe_errors(input int unsigned count);
      decoded_type e;
      e.cp = '0;
      e.err = 1'b1;
      e.last = 1'b0;
      for (int unsigned i = 0; i < count; i++) owe_item(e);
   endfunction

   function automatic void open_or_pass(input logic [7:0] b);
      decoded_type v;
      v.cp = CP_W'(b);
      v.err = 1'b0;
      v.last = 1'b0;
      if (b < ASCII_LIM) begin
         owe_item(v);
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         seq_len = LEN_TWO;
         acc = CP_W'(b[4:0]);
         held = 2'd1;
      end else if (b[7:4] == LEAD3_NIB) begin
         seq_len = LEN_THREE;
         acc = CP_W'(b[3:0]);
         held = 2'd1;
      end else if (b[7:4] == LEAD4_NIB && b <= LEAD4_HI) begin
         seq_len = LEN_FOUR;
         acc = CP_W'(b[2:0]);
         held = 2'd1;
      end else begin
         owe_errors(1);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eot);
      int unsigned     first;
      logic [CP_W-1:0] floor;
      decoded_type     v;
      first = owed_q.size();
      if (held != 2'd0) begin
         if ((b & CONT_MASK) == CONT_CODE) begin
            acc = {acc[CP_W-7:0], b[5:0]};
            if (int'(held) + 1 >= int'(seq_len)) begin
               floor = (seq_len == LEN_TWO) ? MIN_LEN2 :
                       (seq_len == LEN_THREE) ? MIN_LEN3 : MIN_LEN4;
               if (acc >= floor && acc <= CP_MAX && !(acc >= SURR_LO && acc <= SURR_HI)) begin
                  v.cp = acc;
                  v.err = 1'b0;
                  v.last = 1'b0;
                  owe_item(v);
               end else begin
                  owe_errors(int'(seq_len));
               end
               close_sequence();
            end else begin
               held = held + 2'd1;
            end
         end else begin
            owe_errors(int'(held));
            close_sequence();
            open_or_pass(b);
         end
      end else begin
         open_or_pass(b);
      end
      if (eot && held != 2'd0) begin
         owe_errors(int'(held));
         close_sequence();
      end
      if (owed_q.size() > first) begin
         v = owed_q.pop_back();
         v.last = 1'b1;
         owe_item(v);
      end
   endfunction

   function automatic void check_result(input decoded_type got);
      decoded_type want;
      if (owed_q.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%t: unexpected result cp=%h err=%b last=%b",
                     $realtime, got.cp, got.err, got.last);
         mismatch_count++;
      end else begin
         want = owed_q.pop_front();
         if (got !== want) begin
            if (mismatch_count < REPORT_LIMIT)
               $display({"%t: result mismatch expected cp=%h err=%b last=%b, ",
                         "got cp=%h err=%b last=%b"},
                        $realtime, want.cp, want.err, want.last, got.cp, got.err, got.last);
            mismatch_count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      decoded_type got;
      if (reset) begin
         close_sequence();
         owed_q.delete();
         mismatch_count = 0;
         results_seen = 0;
         error_results = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            decode_byte(req_chan.data_byte, req_chan.end_of_text);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.cp = rsp_chan.code_point;
            got.err = rsp_chan.is_error;
            got.last = rsp_chan.last_of_run;
            results_seen++;
            if (got.err === 1'b1) error_results++;
            check_result(got);
         end
      end
      results_owed = owed_q.size();
   end

endmodule

@@ verif/utf8_stream_decoder_test.sv @@
`timescale 1ns / 1ps
module utf8_stream_decoder_test
   import utf8d_pkg::*;
();

   localparam int unsigned BYTE_TARGET = 350;
   localparam int unsigned HOLD_CYCLES = 48;
   localparam int unsigned HOLD_AT     = 120;
   localparam int unsigned DRAIN_AT    = 230;
   localparam int unsigned IDLE_LIMIT  = 2000;

   typedef struct packed {
      logic [7:0] value;
      logic       eot;
   } text_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off_req = 1'b0;
   logic hold_done = 1'b0;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned results_seen;
   int unsigned error_results;
   int unsigned idle_cycles = 0;
   int unsigned eot_count = 0;

   text_byte_type text_q[$];

   utf8d_req_if req_chan ();
   utf8d_rsp_if rsp_chan ();

   utf8_stream_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utf8_stream_decoder_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed),
      .results_seen   (results_seen),
      .error_results  (error_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_byte(input logic [7:0] b, input logic eot);
      text_byte_type t;
      t.value = b;
      t.eot = eot;
      text_q.insert(text_q.size(), t);
      if (eot) eot_count++;
   endfunction

   function automatic void add_text_byte(input logic [7:0] b);
      add_byte(b, $urandom_range(0, 19) == 0);
   endfunction

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(8'hbf, 8'h80));
   endfunction

   function automatic logic [7:0] lead_for(input int unsigned len);
      if (len == 2) return 8'($urandom_range(LEAD2_HI, LEAD2_LO));
      if (len == 3) return {LEAD3_NIB, 4'($urandom_range(15, 0))};
      return 8'($urandom_range(LEAD4_HI, {LEAD4_NIB, 4'h0}));
   endfunction

   function automatic void add_char();
      int unsigned pick;
      int unsigned len;
      int unsigned keep;
      logic [7:0]  lead;
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
         add_text_byte(8'($urandom_range(8'h7f, 0)));
      end else if (pick < 45) begin
         add_text_byte(lead_for(2));
         add_text_byte(any_cont());
      end else if (pick < 62) begin
         lead = lead_for(3);
         add_text_byte(lead);
         if (lead == 8'he0) add_text_byte(8'($urandom_range(8'hbf, 8'ha0)));
         else if (lead == 8'hed) add_text_byte(8'($urandom_range(8'h9f, 8'h80)));
         else add_text_byte(any_cont());
         add_text_byte(any_cont());
      end else if (pick < 75) begin
         lead = lead_for(4);
         add_text_byte(lead);
         if (lead == 8'hf0) add_text_byte(8'($urandom_range(8'hbf, 8'h90)));
         else if (lead == LEAD4_HI) add_text_byte(8'($urandom_range(8'h8f, 8'h80)));
         else add_text_byte(any_cont());
         add_text_byte(any_cont());
         add_text_byte(any_cont());
      end else if (pick < 83) begin
         add_text_byte(8'($urandom_range(8'hff, 0)));
      end else if (pick < 91) begin
         // truncated sequence, broken by whatever comes next
         len = $urandom_range(4, 2);
         keep = $urandom_range(len - 2, 0);
         add_text_byte(lead_for(len));
         for (int unsigned i = 0; i < keep; i++) add_text_byte(any_cont());
      end else begin
         // full length with free continuations: overlong, surrogate, too large
         len = $urandom_range(4, 2);
         add_text_byte(lead_for(len));
         for (int unsigned i = 1; i < len; i++) add_text_byte(any_cont());
      end
   endfunction

   task automatic put_item(input text_byte_type t);
      req_chan.valid = 1'b1;
      req_chan.data_byte = t.value;
      req_chan.end_of_text = t.eot;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (results_owed != 0);
   endtask

   // result side stall pattern, with one long hold-off on request
   initial begin
      int unsigned cyc;
      int unsigned mode;
      cyc = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         mode = (cyc / 40) % 4;
         cyc++;
         case (mode)
            0: rsp_chan.ready = 1'b1;
            1: rsp_chan.ready = ($urandom_range(3, 0) != 0);
            2: rsp_chan.ready = ((cyc % 3) != 0);
            default: rsp_chan.ready = 1'($urandom_range(1, 0));
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned idx;
      int unsigned burst;
      int unsigned gap;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.end_of_text = 1'b0;

      // extremes, invalid leads, strays, every sequence length, three- and four-byte failures
      add_byte(8'h00, 1'b0);
      add_byte(8'h7f, 1'b1);
      add_byte(8'h80, 1'b0);
      add_byte(8'hc0, 1'b0);
      add_byte(8'hff, 1'b0);
      add_byte(8'hc2, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'hed, 1'b0);
      add_byte(8'ha0, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'hf4, 1'b0);
      add_byte(8'h90, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'he0, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'he2, 1'b0);
      add_byte(8'h41, 1'b0);
      add_byte(8'hf0, 1'b0);
      add_byte(8'h90, 1'b0);
      add_byte(8'h80, 1'b1);
      add_byte(8'hf4, 1'b0);
      add_byte(8'h8f, 1'b0);
      add_byte(8'hbf, 1'b0);
      add_byte(8'hbf, 1'b1);
      while (text_q.size() < BYTE_TARGET) add_char();

      repeat (10) @(negedge clock);
      reset = 1'b0;

      idx = 0;
      while (idx < text_q.size()) begin
         burst = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 30) : $urandom_range(10, 1);
         while (burst > 0 && idx < text_q.size()) begin
            if (idx == HOLD_AT) hold_off_req = 1'b1;
            if (idx == DRAIN_AT) begin
               req_chan.valid = 1'b0;
               wait_drained();
            end
            put_item(text_q[idx]);
            idx++;
            burst--;
         end
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_chan.valid = 1'b0;
      wait_drained();
      repeat (8) @(negedge clock);

      $display("sent %0d text bytes (%0d with end of text) through all lead classes and failures",
               text_q.size(), eot_count);
      $display("checked %0d results: %0d code points, %0d error markers",
               results_seen, results_seen - error_results, error_results);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ utf8_stream_decoder.f @@
design/utf8d_pkg.sv
design/utf8d_if.sv
design/utf8d_decode.sv
design/utf8_stream_decoder.sv
design/utf8d_checker.sv
verif/utf8_stream_decoder_checker.sv
verif/utf8_stream_decoder_test.sv
